// ----- hw/rtl/b2il_pkg.sv -----
// shared widths and types for the bitmap to index list block
`default_nettype none
package b2il_pkg;
    localparam int LANES      = 8;
    localparam int LANE_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 30;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [LANE_W-1:0] lane_t;
    typedef logic [POS_W-1:0]  pos_t;
endpackage
`default_nettype wire

// ----- hw/rtl/b2il_if.sv -----
// valid/ready channel interfaces for bitmap bytes and index results
`default_nettype none
interface b2il_byte_if;
    logic            valid;
    logic            ready;
    b2il_pkg::byte_t bitmap_byte;
    logic            start_req;

    modport source (output valid, output bitmap_byte, output start_req, input ready);
    modport sink (input valid, input bitmap_byte, input start_req, output ready);
endinterface

interface b2il_index_if;
    logic            valid;
    logic            ready;
    logic            is_total;
    b2il_pkg::word_t value;
    b2il_pkg::word_t slot;
    logic            end_of_run;

    modport source (output valid, output is_total, output value, output slot,
                    output end_of_run, input ready);
    modport sink (input valid, input is_total, input value, input slot,
                  input end_of_run, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bitmap_to_index_list.sv -----
// bitmap to index list compaction, one bitmap byte per input word
//
//  channel   dir  payload                                  handshake
//  bitmap    in   bitmap_byte[7:0], start_req              valid/ready
//  indices   out  is_total, value[31:0], slot[31:0], eor   valid/ready
//  cfg       in   cfg_wdata[31:0] (element_count)          cfg_we
//
// a byte yields one result per set bit in range, plus a closing total if it is
// the last byte in range; a byte with no result is taken but gives no output
// the emit stage hands out one result per cycle into the output register while the output is not stalled
// a new byte is taken while the emit stage is idle or in the cycle it hands off its last result
// rst_n clears position, count, finished flag, element_count and all valids
// a stalled output holds its word; the emit stage behind it then waits
`default_nettype none
module bitmap_to_index_list (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire b2il_pkg::word_t cfg_wdata,
    b2il_byte_if.sink          bitmap,
    b2il_index_if.source       indices
);
    // persistent state
    b2il_pkg::word_t elem_cnt_reg;
    b2il_pkg::pos_t  pos_reg;
    b2il_pkg::word_t sel_cnt_reg;
    logic            finished_reg;

    // emit stage
    logic [b2il_pkg::LANES-1:0]         mask_reg, mask_next;
    logic [b2il_pkg::WORD_W-b2il_pkg::LANE_W-1:0] hi_reg;
    b2il_pkg::word_t                    slot_reg;
    logic                               total_reg, total_next;
    b2il_pkg::word_t                    total_val_reg;

    // output register
    logic            out_valid_reg;
    logic            out_is_total_reg;
    b2il_pkg::word_t out_value_reg;
    b2il_pkg::word_t out_slot_reg;
    logic            out_eor_reg;

    // input side decode
    b2il_pkg::pos_t             pos0;
    b2il_pkg::word_t            cnt0;
    logic [b2il_pkg::POS_W+2:0] base;
    logic signed [b2il_pkg::POS_W+3:0] rem;
    logic [b2il_pkg::LANES-1:0] lane_ok;
    logic [b2il_pkg::LANES-1:0] sel;
    logic [b2il_pkg::LANE_W:0]  pop;
    logic                       is_last;
    logic                       proceed;
    logic                       has_res;
    logic                       accept;
    b2il_pkg::word_t            cnt_new;

    // emit decode
    logic            work_active;
    logic            work_adv;
    b2il_pkg::lane_t low_lane;
    logic            emit_total;
    logic            emit_last;

    always_comb
    begin
        pos0    = bitmap.start_req ? '0 : pos_reg;
        cnt0    = bitmap.start_req ? '0 : sel_cnt_reg;
        proceed = bitmap.start_req || !finished_reg;
        base    = {pos0, {b2il_pkg::LANE_W{1'b0}}};
        rem     = $signed({2'b00, elem_cnt_reg}) - $signed({1'b0, base});
        for (int k = 0; k < b2il_pkg::LANES; k++)
        begin
            lane_ok[k] = rem > $signed((b2il_pkg::POS_W+4)'(k));
        end
        sel     = bitmap.bitmap_byte & lane_ok;
        pop     = (b2il_pkg::LANE_W+1)'($countones(sel));
        is_last = rem <= $signed((b2il_pkg::POS_W+4)'(b2il_pkg::LANES));
        has_res = proceed && ((sel != '0) || is_last);
        cnt_new = cnt0 + b2il_pkg::WORD_W'(pop);
    end

    always_comb
    begin
        low_lane = '0;
        for (int k = b2il_pkg::LANES - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
            begin
                low_lane = b2il_pkg::LANE_W'(k);
            end
        end
        work_active = (mask_reg != '0) || total_reg;
        emit_total  = (mask_reg == '0);
        emit_last   = emit_total || (((mask_reg & (mask_reg - 1'b1)) == '0) && !total_reg);
        work_adv    = work_active && (!out_valid_reg || indices.ready);
        mask_next   = mask_reg & (mask_reg - 1'b1);
        total_next  = total_reg && !emit_total;
    end

    assign bitmap.ready = !work_active || (work_adv && emit_last);
    assign accept       = bitmap.valid && bitmap.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_cnt_reg <= '0;
            pos_reg      <= '0;
            sel_cnt_reg  <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                elem_cnt_reg <= cfg_wdata;
            end
            if (accept && proceed)
            begin
                sel_cnt_reg <= cnt_new;
                if (is_last)
                begin
                    finished_reg <= 1'b1;
                    pos_reg      <= pos0;
                end
                else
                begin
                    finished_reg <= 1'b0;
                    pos_reg      <= pos0 + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            total_reg <= 1'b0;
        end
        else if (accept && has_res)
        begin
            mask_reg  <= sel;
            total_reg <= is_last;
        end
        else if (work_adv)
        begin
            mask_reg  <= mask_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_res)
        begin
            hi_reg        <= base[b2il_pkg::WORD_W-1:b2il_pkg::LANE_W];
            slot_reg      <= cnt0;
            total_val_reg <= cnt_new;
        end
        else if (work_adv && !emit_total)
        begin
            slot_reg <= slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (work_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (indices.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_adv)
        begin
            out_is_total_reg <= emit_total;
            out_value_reg    <= emit_total ? total_val_reg : {hi_reg, low_lane};
            out_slot_reg     <= emit_total ? '0 : slot_reg;
            out_eor_reg      <= emit_last;
        end
    end

    assign indices.valid      = out_valid_reg;
    assign indices.is_total   = out_is_total_reg;
    assign indices.value      = out_value_reg;
    assign indices.slot       = out_slot_reg;
    assign indices.end_of_run = out_eor_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/b2il_checker.sv -----
// port level checks for the bitmap to index list block, bound to the top level
`default_nettype none
module b2il_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire logic            out_is_total,
    input wire b2il_pkg::word_t out_value,
    input wire b2il_pkg::word_t out_slot,
    input wire logic            out_eor
);
    // a total closes the run of its byte
    a_total_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_is_total |-> out_eor)
        else $error("total word without end_of_run");

    // a total carries slot zero
    a_total_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_is_total |-> out_slot == '0)
        else $error("total word with nonzero slot");

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_slot)
            && $stable(out_is_total) && $stable(out_eor))
        else $error("stalled output word changed");

    // an index word not ending its run is followed by the next index of that byte or by the closing total
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_is_total && !out_eor |=>
            out_valid && (out_is_total || out_slot == $past(out_slot) + 1'b1))
        else $error("run broken before end_of_run");
endmodule

bind bitmap_to_index_list b2il_checker u_b2il_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (indices.valid),
    .out_ready    (indices.ready),
    .out_is_total (indices.is_total),
    .out_value    (indices.value),
    .out_slot     (indices.slot),
    .out_eor      (indices.end_of_run)
);
`default_nettype wire
